FILE: rtl/core/svs_pkg.sv
// Shared types, constants and the quarter-wave sine table for the voice core.
// No dependencies; the top level and the divider use it by scoped names.
`default_nettype none

package svs_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_QTR        = 1 << (SINE_TABLE_BITS - 2);
    localparam int SINE_IDX_W      = SINE_TABLE_BITS - 1;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned SINE_DIV [0:4] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef logic [16:0] t_sine_rom [0:SINE_QTR];

    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ENV_OFF     = 2'd0,
        ENV_ATTACK  = 2'd1,
        ENV_HOLD    = 2'd2,
        ENV_RELEASE = 2'd3
    } t_env;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ENV,
        ST_ENV_WB,
        ST_PHASE,
        ST_SYNC_DIV,
        ST_SYNC_WAIT,
        ST_WAVE,
        ST_TRI_WAIT,
        ST_NOISE,
        ST_FLT_HP_MUL,
        ST_FLT_HP,
        ST_FLT_BP_MUL,
        ST_FLT_BP,
        ST_FLT_LP_MUL,
        ST_FLT_LP,
        ST_FLT_MIX,
        ST_RING_MUL,
        ST_RING_K,
        ST_RING_LO,
        ST_RING_HI,
        ST_RING_SUM,
        ST_SMTH_V,
        ST_SMTH_KEEP,
        ST_SMTH_TAKE,
        ST_SMTH_WB,
        ST_OUT_L,
        ST_OUT_R,
        ST_DONE
    } t_state;

    localparam logic [1:0] WAVE_PULSE = 2'd0;
    localparam logic [1:0] WAVE_TRI   = 2'd1;
    localparam logic [1:0] WAVE_SINE  = 2'd2;
    localparam logic [1:0] WAVE_NOISE = 2'd3;

    localparam logic [2:0] CFG_WAVE_MODE      = 3'd0;
    localparam logic [2:0] CFG_ATTACK_STEP    = 3'd1;
    localparam logic [2:0] CFG_DECAY_FACTOR   = 3'd2;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL  = 3'd3;
    localparam logic [2:0] CFG_RELEASE_FACTOR = 3'd4;
    localparam logic [2:0] CFG_FILTER_MODE    = 3'd5;
    localparam logic [2:0] CFG_CUTOFF         = 3'd6;
    localparam logic [2:0] CFG_RESONANCE_DAMP = 3'd7;

    localparam int FLT_LOW_BIT  = 0;
    localparam int FLT_BAND_BIT = 1;
    localparam int FLT_HIGH_BIT = 2;

    localparam logic [16:0] UNITY        = 17'd65536;
    localparam logic [16:0] REL_FLOOR    = 17'd7;
    localparam logic [24:0] NOISE_TICK   = 25'd1677722;
    localparam logic [24:0] PHASE_ONE    = 25'h1000000;
    localparam logic [15:0] SMOOTH_KEEP  = 16'd63570;
    localparam logic [10:0] SMOOTH_TAKE  = 11'd1966;
    localparam logic [22:0] NOISE_SEED   = 23'h7fffff;
    localparam logic [4:0]  DIV_ITERS_SYNC = 5'd24;
    localparam logic [4:0]  DIV_ITERS_TRI  = 5'd17;

    typedef struct packed {
        logic       start;
        logic [4:0] iters;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic signed [19:0] sat20(input logic signed [63:0] v);
        if (v > 64'sd524287) begin
            return 20'sh7ffff;
        end
        if (v < -64'sd524288) begin
            return 20'sh80000;
        end
        return v[19:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        for (int j = 0; j <= SINE_QTR; j++) begin
            x  = (64'(j) * TWO_PI_Q30) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            for (int k = 0; k < 5; k++) begin
                t = (64'd1 << 30) - ((x2 * t) >> 30) / SINE_DIV[k];
            end
            rom[j] = 17'((((x * t) >> 30) + 64'd8192) >> 14);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: rtl/core/svs_div.sv
// Restoring divider, one quotient bit per cycle, for phase sync and triangle slopes.
// Depends on svs_pkg for the control and status structs.
`default_nettype none

module svs_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire svs_pkg::t_div_ctl i_ctl,
    input  wire logic [24:0]      i_rem0,
    input  wire logic [23:0]      i_low,
    input  wire logic [24:0]      i_divisor,
    output      svs_pkg::t_div_stat o_stat,
    output      logic [23:0]      o_quot
);

    logic [24:0] r_rem;
    logic [23:0] r_low;
    logic [24:0] r_div;
    logic [23:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [25:0] shifted;
    logic        fits;

    // The partial remainder always stays below the divisor, so it fits 25 bits.
    assign shifted = {r_rem, r_low[23]};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= i_rem0;
            r_low  <= i_low;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? 25'(shifted - {1'b0, r_div}) : shifted[24:0];
            r_low  <= {r_low[22:0], 1'b0};
            r_quot <= {r_quot[22:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire

FILE: rtl/core/synth_voice_sample_top.sv
// One synthesizer voice: envelope, oscillator, filter, ring modulation and stereo gain.
// A note-on or note-off beat is handled in the idle state, and a sample beat on a silent voice
// goes straight to the done state; an active sample beat's length is set by the one-bit-per-cycle
// divider (sync and triangle) and the one-tick-per-cycle noise register loop. One sample beat is in
// work at a time; a finished result waits in the output register while the next beat is taken. Reset
// is synchronous, active low, and returns the voice, its configuration and both handshakes to idle.
`default_nettype none

module synth_voice_sample_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input item channel.
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic [1:0]         i_op,
    input  wire logic [23:0]        i_phase_step,
    input  wire logic [23:0]        i_pulse_width,
    input  wire logic [18:0]        i_left_gain,
    input  wire logic [18:0]        i_right_gain,
    input  wire logic               i_sync_enable,
    input  wire logic [16:0]        i_ring_mix,
    input  wire logic [24:0]        i_mod_phase,
    input  wire logic [23:0]        i_mod_step,
    input  wire logic signed [19:0] i_mod_amp,
    // Result channel.
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic signed [19:0] o_left_sample,
    output      logic signed [19:0] o_right_sample,
    output      logic signed [19:0] o_voice_amp,
    output      logic [24:0]        o_voice_phase,
    output      logic               o_voice_active,
    // Configuration write port.
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [24:0]        i_cfg_wdata
);

    // ------------------------------------------------------------------
    // Registers. Every multiply of the sample goes through one shared
    // 26 x 26 signed multiplier whose product lands in r_prod; the state
    // after the one that chose the operands consumes it.
    // ------------------------------------------------------------------
    svs_pkg::t_state r_state, n_state;
    svs_pkg::t_env   r_env_state, n_env_state;

    logic [1:0]  r_wave_mode, n_wave_mode;
    logic [24:0] r_attack, n_attack;
    logic [23:0] r_decay, n_decay;
    logic [16:0] r_sustain, n_sustain;
    logic [23:0] r_release, n_release;
    logic [2:0]  r_flt_mode, n_flt_mode;
    logic [16:0] r_cutoff, n_cutoff;
    logic [16:0] r_damp, n_damp;

    logic [16:0]        r_env_level, n_env_level;
    logic [24:0]        r_phase, n_phase;
    logic [22:0]        r_noise, n_noise;
    logic signed [19:0] r_flt_low, n_flt_low;
    logic signed [19:0] r_flt_band, n_flt_band;
    logic signed [19:0] r_flt_high, n_flt_high;
    logic [19:0]        r_sm_left, n_sm_left;
    logic [19:0]        r_sm_right, n_sm_right;
    logic signed [19:0] r_last_amp, n_last_amp;
    logic               r_side, n_side;
    logic               r_out_valid, n_out_valid;

    logic [23:0]        r_step, n_step;
    logic [23:0]        r_pw, n_pw;
    logic [18:0]        r_lg, n_lg;
    logic [18:0]        r_rg, n_rg;
    logic               r_sync, n_sync;
    logic [16:0]        r_ring, n_ring;
    logic [24:0]        r_mph, n_mph;
    logic [23:0]        r_mst, n_mst;
    logic signed [19:0] r_mamp, n_mamp;
    logic signed [19:0] r_amp, n_amp;
    logic signed [19:0] r_left, n_left;
    logic signed [19:0] r_right, n_right;
    logic signed [37:0] r_k, n_k;
    logic signed [39:0] r_acc, n_acc;
    logic [18:0]        r_v, n_v;
    logic               r_tri_up, n_tri_up;
    logic signed [51:0] r_prod;

    logic signed [19:0] r_o_left, n_o_left;
    logic signed [19:0] r_o_right, n_o_right;
    logic signed [19:0] r_o_amp, n_o_amp;
    logic [24:0]        r_o_phase, n_o_phase;
    logic               r_o_active, n_o_active;

    // Shared multiplier.
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] mul_p;

    // Divider hookup.
    svs_pkg::t_div_ctl  div_ctl;
    svs_pkg::t_div_stat div_stat;
    logic [24:0]        div_rem0;
    logic [23:0]        div_low;
    logic [24:0]        div_divisor;
    logic [23:0]        div_quot;

    logic in_acc;
    logic out_acc;
    logic out_load;

    // Combinational helpers.
    logic [16:0]        sus;
    logic [16:0]        cut;
    logic signed [17:0] env_diff;
    logic [17:0]        atk_inc;
    logic [18:0]        atk_sum;
    logic signed [18:0] hold_delta;
    logic [24:0]        phase_sum;
    logic               sync_hit;
    logic               tri_up;
    logic [svs_pkg::SINE_TABLE_BITS-1:0] sine_idx;
    logic [svs_pkg::SINE_IDX_W-1:0]      sine_addr;
    logic [16:0]        sine_mag;
    logic signed [19:0] sine_amp;
    logic [11:0]        noise_bits;
    logic signed [19:0] noise_amp;
    logic [22:0]        noise_next;
    logic signed [19:0] tri_amp;
    logic signed [22:0] hp_sum;
    logic signed [21:0] bp_sum;
    logic signed [21:0] lp_sum;
    logic signed [21:0] mix_sum;
    logic [32:0]        ring_dry;
    logic signed [57:0] ring_sum;
    logic [39:0]        sm_sum;
    logic [23:0]        sm_val;
    logic               to_filter;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = r_out_valid && i_out_ready;
    assign out_load = (r_state == svs_pkg::ST_DONE) && (!r_out_valid || i_out_ready);

    assign mul_p = mul_a * mul_b;

    // Registers above their range act as full scale.
    assign sus = (r_sustain > svs_pkg::UNITY) ? svs_pkg::UNITY : r_sustain;
    assign cut = (r_cutoff > svs_pkg::UNITY) ? svs_pkg::UNITY : r_cutoff;

    assign env_diff   = $signed({1'b0, r_env_level}) - $signed({1'b0, sus});
    assign atk_inc    = 18'((26'(r_attack) + 26'd128) >> 8);
    assign atk_sum    = 19'(r_env_level) + 19'(atk_inc);
    assign hold_delta = r_prod[42:24];

    // The phase wraps at one in tonal modes and at two in noise mode.
    always_comb begin
        phase_sum = 25'(r_phase + {1'b0, r_step});
        if (r_wave_mode != svs_pkg::WAVE_NOISE) begin
            phase_sum[24] = 1'b0;
        end
    end

    assign sync_hit = r_sync && (r_mph < {1'b0, r_mst});
    assign tri_up   = r_phase < {1'b0, r_pw};

    // Quarter-wave sine: odd quadrants read the table backward, the upper
    // half of the cycle negates.
    assign sine_idx  = r_phase[23 -: svs_pkg::SINE_TABLE_BITS];
    assign sine_addr = sine_idx[svs_pkg::SINE_TABLE_BITS-2]
                     ? svs_pkg::SINE_IDX_W'(svs_pkg::SINE_QTR)
                       - {1'b0, sine_idx[svs_pkg::SINE_TABLE_BITS-3:0]}
                     : {1'b0, sine_idx[svs_pkg::SINE_TABLE_BITS-3:0]};
    assign sine_mag  = svs_pkg::SINE_ROM[sine_addr];
    assign sine_amp  = sine_idx[svs_pkg::SINE_TABLE_BITS-1]
                     ? -$signed({3'b0, sine_mag}) : $signed({3'b0, sine_mag});

    assign noise_next = {r_noise[21:0], r_noise[22] ^ r_noise[17]};
    assign noise_bits = {r_noise[22], r_noise[20], r_noise[16], r_noise[13],
                         r_noise[11], r_noise[7], r_noise[4], r_noise[2], 4'b0};
    assign noise_amp  = $signed({3'b0, noise_bits, 5'b0}) - 20'sd65536;

    assign tri_amp = r_tri_up ? $signed({3'b0, div_quot[16:0]}) - 20'sd65536
                              : 20'sd65536 - $signed({3'b0, div_quot[16:0]});

    assign hp_sum = 23'(r_amp) - 23'($signed(r_prod[36:16])) - 23'(r_flt_low);
    assign bp_sum = 22'(r_flt_band) + 22'($signed(r_prod[36:16]));
    assign lp_sum = 22'(r_flt_low) + 22'($signed(r_prod[36:16]));

    always_comb begin
        mix_sum = '0;
        if (r_flt_mode[svs_pkg::FLT_LOW_BIT]) begin
            mix_sum = mix_sum + 22'(r_flt_low);
        end
        if (r_flt_mode[svs_pkg::FLT_BAND_BIT]) begin
            mix_sum = mix_sum + 22'(r_flt_band);
        end
        if (r_flt_mode[svs_pkg::FLT_HIGH_BIT]) begin
            mix_sum = mix_sum + 22'(r_flt_high);
        end
    end

    // Ring gain K = (1 - r) * 2^32 + mod_amp * r * 2^16 in two slices; the
    // product amp * K is rebuilt from amp * K[18:0] and amp * K[37:19].
    assign ring_dry = {svs_pkg::UNITY - r_ring, 16'b0};
    assign ring_sum = (58'($signed(r_prod[37:0])) <<< 19) + 58'(r_acc);

    assign sm_sum = 40'(r_acc) + 40'(r_prod[39:0]) + 40'd32768;
    assign sm_val = sm_sum[39:16];

    assign to_filter = (r_flt_mode != 3'd0);

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            svs_pkg::ST_IDLE: begin
                if (in_acc && (i_op == svs_pkg::OP_SAMPLE)) begin
                    n_state = (r_env_state == svs_pkg::ENV_OFF) ? svs_pkg::ST_DONE
                                                                : svs_pkg::ST_ENV;
                end
            end
            svs_pkg::ST_ENV: begin
                n_state = (r_env_state == svs_pkg::ENV_ATTACK) ? svs_pkg::ST_PHASE
                                                               : svs_pkg::ST_ENV_WB;
            end
            svs_pkg::ST_ENV_WB:    n_state = svs_pkg::ST_PHASE;
            svs_pkg::ST_PHASE: begin
                n_state = sync_hit ? svs_pkg::ST_SYNC_DIV : svs_pkg::ST_WAVE;
            end
            svs_pkg::ST_SYNC_DIV:  n_state = svs_pkg::ST_SYNC_WAIT;
            svs_pkg::ST_SYNC_WAIT: begin
                if (div_stat.done) begin
                    n_state = svs_pkg::ST_WAVE;
                end
            end
            svs_pkg::ST_WAVE: begin
                case (r_wave_mode)
                    svs_pkg::WAVE_TRI:   n_state = svs_pkg::ST_TRI_WAIT;
                    svs_pkg::WAVE_NOISE: n_state = svs_pkg::ST_NOISE;
                    default: begin
                        n_state = to_filter ? svs_pkg::ST_FLT_HP_MUL : svs_pkg::ST_RING_MUL;
                    end
                endcase
            end
            svs_pkg::ST_TRI_WAIT: begin
                if (div_stat.done) begin
                    n_state = to_filter ? svs_pkg::ST_FLT_HP_MUL : svs_pkg::ST_RING_MUL;
                end
            end
            svs_pkg::ST_NOISE: begin
                if (r_phase <= svs_pkg::NOISE_TICK) begin
                    n_state = to_filter ? svs_pkg::ST_FLT_HP_MUL : svs_pkg::ST_RING_MUL;
                end
            end
            svs_pkg::ST_FLT_HP_MUL: n_state = svs_pkg::ST_FLT_HP;
            svs_pkg::ST_FLT_HP:     n_state = svs_pkg::ST_FLT_BP_MUL;
            svs_pkg::ST_FLT_BP_MUL: n_state = svs_pkg::ST_FLT_BP;
            svs_pkg::ST_FLT_BP:     n_state = svs_pkg::ST_FLT_LP_MUL;
            svs_pkg::ST_FLT_LP_MUL: n_state = svs_pkg::ST_FLT_LP;
            svs_pkg::ST_FLT_LP:     n_state = svs_pkg::ST_FLT_MIX;
            svs_pkg::ST_FLT_MIX:    n_state = svs_pkg::ST_RING_MUL;
            svs_pkg::ST_RING_MUL:   n_state = svs_pkg::ST_RING_K;
            svs_pkg::ST_RING_K:     n_state = svs_pkg::ST_RING_LO;
            svs_pkg::ST_RING_LO:    n_state = svs_pkg::ST_RING_HI;
            svs_pkg::ST_RING_HI:    n_state = svs_pkg::ST_RING_SUM;
            svs_pkg::ST_RING_SUM:   n_state = svs_pkg::ST_SMTH_V;
            svs_pkg::ST_SMTH_V:     n_state = svs_pkg::ST_SMTH_KEEP;
            svs_pkg::ST_SMTH_KEEP:  n_state = svs_pkg::ST_SMTH_TAKE;
            svs_pkg::ST_SMTH_TAKE:  n_state = svs_pkg::ST_SMTH_WB;
            svs_pkg::ST_SMTH_WB: begin
                n_state = r_side ? svs_pkg::ST_OUT_L : svs_pkg::ST_SMTH_V;
            end
            svs_pkg::ST_OUT_L:      n_state = svs_pkg::ST_OUT_R;
            svs_pkg::ST_OUT_R:      n_state = svs_pkg::ST_DONE;
            svs_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = svs_pkg::ST_IDLE;
                end
            end
            default:                n_state = svs_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and control outputs.
    // ------------------------------------------------------------------
    always_comb begin
        n_env_state = r_env_state;
        n_env_level = r_env_level;
        n_phase     = r_phase;
        n_noise     = r_noise;
        n_flt_low   = r_flt_low;
        n_flt_band  = r_flt_band;
        n_flt_high  = r_flt_high;
        n_sm_left   = r_sm_left;
        n_sm_right  = r_sm_right;
        n_last_amp  = r_last_amp;
        n_side      = r_side;
        n_step      = r_step;
        n_pw        = r_pw;
        n_lg        = r_lg;
        n_rg        = r_rg;
        n_sync      = r_sync;
        n_ring      = r_ring;
        n_mph       = r_mph;
        n_mst       = r_mst;
        n_mamp      = r_mamp;
        n_amp       = r_amp;
        n_left      = r_left;
        n_right     = r_right;
        n_k         = r_k;
        n_acc       = r_acc;
        n_v         = r_v;
        n_tri_up    = r_tri_up;
        n_o_left    = r_o_left;
        n_o_right   = r_o_right;
        n_o_amp     = r_o_amp;
        n_o_phase   = r_o_phase;
        n_o_active  = r_o_active;
        n_out_valid = r_out_valid;
        mul_a       = '0;
        mul_b       = '0;
        div_ctl     = '0;
        div_rem0    = '0;
        div_low     = '0;
        div_divisor = '0;
        o_in_ready  = 1'b0;

        n_wave_mode = r_wave_mode;
        n_attack    = r_attack;
        n_decay     = r_decay;
        n_sustain   = r_sustain;
        n_release   = r_release;
        n_flt_mode  = r_flt_mode;
        n_cutoff    = r_cutoff;
        n_damp      = r_damp;
        if (i_cfg_we) begin
            case (i_cfg_index)
                svs_pkg::CFG_WAVE_MODE:      n_wave_mode = i_cfg_wdata[1:0];
                svs_pkg::CFG_ATTACK_STEP:    n_attack    = i_cfg_wdata;
                svs_pkg::CFG_DECAY_FACTOR:   n_decay     = i_cfg_wdata[23:0];
                svs_pkg::CFG_SUSTAIN_LEVEL:  n_sustain   = i_cfg_wdata[16:0];
                svs_pkg::CFG_RELEASE_FACTOR: n_release   = i_cfg_wdata[23:0];
                svs_pkg::CFG_FILTER_MODE:    n_flt_mode  = i_cfg_wdata[2:0];
                svs_pkg::CFG_CUTOFF:         n_cutoff    = i_cfg_wdata[16:0];
                svs_pkg::CFG_RESONANCE_DAMP: n_damp      = i_cfg_wdata[16:0];
                default: ;
            endcase
        end

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            svs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    n_step = i_phase_step;
                    n_pw   = i_pulse_width;
                    n_lg   = i_left_gain;
                    n_rg   = i_right_gain;
                    n_sync = i_sync_enable;
                    n_ring = (i_ring_mix > svs_pkg::UNITY) ? svs_pkg::UNITY : i_ring_mix;
                    n_mph  = i_mod_phase;
                    n_mst  = i_mod_step;
                    n_mamp = i_mod_amp;
                    n_side = 1'b0;
                    case (i_op)
                        svs_pkg::OP_SAMPLE: begin
                            // A silent voice answers with zero samples at once.
                            n_left  = '0;
                            n_right = '0;
                        end
                        svs_pkg::OP_NOTE_ON: begin
                            n_env_state = svs_pkg::ENV_ATTACK;
                            n_env_level = '0;
                            n_phase     = '0;
                        end
                        svs_pkg::OP_NOTE_OFF: begin
                            if (r_env_state != svs_pkg::ENV_OFF) begin
                                n_env_state = svs_pkg::ENV_RELEASE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            svs_pkg::ST_ENV: begin
                if (r_env_state == svs_pkg::ENV_ATTACK) begin
                    if (atk_sum > 19'(svs_pkg::UNITY)) begin
                        n_env_level = svs_pkg::UNITY;
                        n_env_state = svs_pkg::ENV_HOLD;
                    end else begin
                        n_env_level = atk_sum[16:0];
                    end
                end else if (r_env_state == svs_pkg::ENV_HOLD) begin
                    mul_a = 26'(env_diff);
                    mul_b = 26'({1'b0, r_decay});
                end else begin
                    mul_a = 26'({1'b0, r_env_level});
                    mul_b = 26'({1'b0, r_release});
                end
            end
            svs_pkg::ST_ENV_WB: begin
                if (r_env_state == svs_pkg::ENV_HOLD) begin
                    n_env_level = 17'($signed({2'b0, sus}) + hold_delta);
                end else begin
                    n_env_level = r_prod[40:24];
                    if (r_prod[40:24] < svs_pkg::REL_FLOOR) begin
                        n_env_state = svs_pkg::ENV_OFF;
                    end
                end
            end
            svs_pkg::ST_PHASE: begin
                n_phase = phase_sum;
                mul_a   = 26'({1'b0, r_mph});
                mul_b   = 26'({1'b0, r_step});
            end
            svs_pkg::ST_SYNC_DIV: begin
                // mod_phase < mod_step keeps the quotient inside 24 bits.
                div_ctl.start = 1'b1;
                div_ctl.iters = svs_pkg::DIV_ITERS_SYNC;
                div_rem0      = r_prod[48:24];
                div_low       = r_prod[23:0];
                div_divisor   = {1'b0, r_mst};
            end
            svs_pkg::ST_SYNC_WAIT: begin
                if (div_stat.done) begin
                    n_phase = {1'b0, div_quot};
                end
            end
            svs_pkg::ST_WAVE: begin
                case (r_wave_mode)
                    svs_pkg::WAVE_PULSE: begin
                        n_amp = tri_up ? -20'sd65536 : 20'sd65536;
                    end
                    svs_pkg::WAVE_TRI: begin
                        // Each slope divides a value that is already below the divisor.
                        n_tri_up      = tri_up;
                        div_ctl.start = 1'b1;
                        div_ctl.iters = svs_pkg::DIV_ITERS_TRI;
                        div_rem0      = tri_up ? r_phase : r_phase - {1'b0, r_pw};
                        div_divisor   = tri_up ? {1'b0, r_pw}
                                               : svs_pkg::PHASE_ONE - {1'b0, r_pw};
                    end
                    svs_pkg::WAVE_SINE: begin
                        n_amp = sine_amp;
                    end
                    default: ;
                endcase
            end
            svs_pkg::ST_TRI_WAIT: begin
                if (div_stat.done) begin
                    n_amp = tri_amp;
                end
            end
            svs_pkg::ST_NOISE: begin
                // One register clock for every tick the phase has crossed.
                if (r_phase > svs_pkg::NOISE_TICK) begin
                    n_phase = r_phase - svs_pkg::NOISE_TICK;
                    n_noise = noise_next;
                end else begin
                    n_amp = noise_amp;
                end
            end
            svs_pkg::ST_FLT_HP_MUL: begin
                mul_a = 26'(r_flt_band);
                mul_b = 26'({1'b0, r_damp});
            end
            svs_pkg::ST_FLT_HP: begin
                n_flt_high = svs_pkg::sat20(64'(hp_sum));
            end
            svs_pkg::ST_FLT_BP_MUL: begin
                mul_a = 26'({1'b0, cut});
                mul_b = 26'(r_flt_high);
            end
            svs_pkg::ST_FLT_BP: begin
                n_flt_band = svs_pkg::sat20(64'(bp_sum));
            end
            svs_pkg::ST_FLT_LP_MUL: begin
                mul_a = 26'({1'b0, cut});
                mul_b = 26'(r_flt_band);
            end
            svs_pkg::ST_FLT_LP: begin
                n_flt_low = svs_pkg::sat20(64'(lp_sum));
            end
            svs_pkg::ST_FLT_MIX: begin
                n_amp = svs_pkg::sat20(64'(mix_sum));
            end
            svs_pkg::ST_RING_MUL: begin
                n_last_amp = r_amp;
                mul_a      = 26'(r_mamp);
                mul_b      = 26'({1'b0, r_ring});
            end
            svs_pkg::ST_RING_K: begin
                n_k = $signed({5'b0, ring_dry}) + 38'($signed(r_prod[36:0]));
            end
            svs_pkg::ST_RING_LO: begin
                mul_a = 26'(r_amp);
                mul_b = 26'({1'b0, r_k[18:0]});
            end
            svs_pkg::ST_RING_HI: begin
                n_acc = 40'($signed(r_prod[38:0]));
                mul_a = 26'(r_amp);
                mul_b = 26'($signed(r_k[37:19]));
            end
            svs_pkg::ST_RING_SUM: begin
                n_amp = svs_pkg::sat20(64'(ring_sum >>> 32));
            end
            svs_pkg::ST_SMTH_V: begin
                mul_a = 26'({1'b0, r_env_level});
                mul_b = 26'({1'b0, r_side ? r_rg : r_lg});
            end
            svs_pkg::ST_SMTH_KEEP: begin
                n_v   = r_prod[34:16];
                mul_a = 26'({1'b0, r_side ? r_sm_right : r_sm_left});
                mul_b = 26'({1'b0, svs_pkg::SMOOTH_KEEP});
            end
            svs_pkg::ST_SMTH_TAKE: begin
                n_acc = r_prod[39:0];
                mul_a = 26'({1'b0, r_v});
                mul_b = 26'({1'b0, svs_pkg::SMOOTH_TAKE});
            end
            svs_pkg::ST_SMTH_WB: begin
                if (r_side) begin
                    n_sm_right = (sm_val > 24'd524287) ? 20'd524287 : sm_val[19:0];
                    // Left gain is final here, so the left product starts now.
                    mul_a = 26'(r_amp);
                    mul_b = 26'({1'b0, r_sm_left});
                end else begin
                    n_sm_left = (sm_val > 24'd524287) ? 20'd524287 : sm_val[19:0];
                    n_side    = 1'b1;
                end
            end
            svs_pkg::ST_OUT_L: begin
                n_left = svs_pkg::sat20(64'($signed(r_prod[39:16])));
                mul_a  = 26'(r_amp);
                mul_b  = 26'({1'b0, r_sm_right});
            end
            svs_pkg::ST_OUT_R: begin
                n_right = svs_pkg::sat20(64'($signed(r_prod[39:16])));
            end
            svs_pkg::ST_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_o_left    = r_left;
                    n_o_right   = r_right;
                    n_o_amp     = r_last_amp;
                    n_o_phase   = r_phase;
                    n_o_active  = (r_env_state != svs_pkg::ENV_OFF);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control, voice state and configuration, set to their defaults by reset.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svs_pkg::ST_IDLE;
            r_env_state <= svs_pkg::ENV_OFF;
            r_env_level <= '0;
            r_phase     <= '0;
            r_noise     <= svs_pkg::NOISE_SEED;
            r_flt_low   <= '0;
            r_flt_band  <= '0;
            r_flt_high  <= '0;
            r_sm_left   <= '0;
            r_sm_right  <= '0;
            r_last_amp  <= '0;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
            r_wave_mode <= svs_pkg::WAVE_PULSE;
            r_attack    <= 25'd380;
            r_decay     <= 24'd16762939;
            r_sustain   <= 17'd32768;
            r_release   <= 24'd16768457;
            r_flt_mode  <= 3'd0;
            r_cutoff    <= 17'd13107;
            r_damp      <= 17'd32768;
        end else begin
            r_state     <= n_state;
            r_env_state <= n_env_state;
            r_env_level <= n_env_level;
            r_phase     <= n_phase;
            r_noise     <= n_noise;
            r_flt_low   <= n_flt_low;
            r_flt_band  <= n_flt_band;
            r_flt_high  <= n_flt_high;
            r_sm_left   <= n_sm_left;
            r_sm_right  <= n_sm_right;
            r_last_amp  <= n_last_amp;
            r_side      <= n_side;
            r_out_valid <= n_out_valid;
            r_wave_mode <= n_wave_mode;
            r_attack    <= n_attack;
            r_decay     <= n_decay;
            r_sustain   <= n_sustain;
            r_release   <= n_release;
            r_flt_mode  <= n_flt_mode;
            r_cutoff    <= n_cutoff;
            r_damp      <= n_damp;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_pw       <= n_pw;
        r_lg       <= n_lg;
        r_rg       <= n_rg;
        r_sync     <= n_sync;
        r_ring     <= n_ring;
        r_mph      <= n_mph;
        r_mst      <= n_mst;
        r_mamp     <= n_mamp;
        r_amp      <= n_amp;
        r_left     <= n_left;
        r_right    <= n_right;
        r_k        <= n_k;
        r_acc      <= n_acc;
        r_v        <= n_v;
        r_tri_up   <= n_tri_up;
        r_prod     <= mul_p;
        r_o_left   <= n_o_left;
        r_o_right  <= n_o_right;
        r_o_amp    <= n_o_amp;
        r_o_phase  <= n_o_phase;
        r_o_active <= n_o_active;
    end

    svs_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (div_ctl),
        .i_rem0    (div_rem0),
        .i_low     (div_low),
        .i_divisor (div_divisor),
        .o_stat    (div_stat),
        .o_quot    (div_quot)
    );

    assign o_out_valid    = r_out_valid;
    assign o_left_sample  = r_o_left;
    assign o_right_sample = r_o_right;
    assign o_voice_amp    = r_o_amp;
    assign o_voice_phase  = r_o_phase;
    assign o_voice_active = r_o_active;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The envelope level never leaves the unit range.
    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env_level <= svs_pkg::UNITY)
        else $error("envelope level above unity");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == svs_pkg::ST_SYNC_WAIT ||
                           r_state == svs_pkg::ST_TRI_WAIT))
        else $error("divider result with nobody waiting");

    // A note-on beat restarts attack from zero phase.
    a_note_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_op == svs_pkg::OP_NOTE_ON) |=>
            (r_env_state == svs_pkg::ENV_ATTACK && r_phase == 25'd0 &&
             r_state == svs_pkg::ST_IDLE))
        else $error("note on did not restart the voice");

    // A loaded result reports the envelope activity of that sample.
    a_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && o_voice_active == (r_env_state != svs_pkg::ENV_OFF)))
        else $error("voice_active does not match the envelope");

endmodule

`default_nettype wire

FILE: test/tb_synth_voice_sample_top.sv
// Self-checking testbench for the synthesizer voice top level.
// Needs svs_pkg and synth_voice_sample_top; it predicts every sample beat
// with its own fixed-point voice model and checks each result beat.
`timescale 1ns / 1ps

module tb_synth_voice_sample_top;

    import svs_pkg::*;

    // One input beat as the driver presents it.
    typedef struct {
        logic [1:0]         op;
        logic [23:0]        step;
        logic [23:0]        pw;
        logic [18:0]        lg;
        logic [18:0]        rg;
        logic               sync;
        logic [16:0]        ring;
        logic [24:0]        mph;
        logic [23:0]        mst;
        logic signed [19:0] mamp;
    } voice_beat_t;

    // One result beat as the voice should produce it.
    typedef struct {
        logic signed [19:0] left;
        logic signed [19:0] right;
        logic signed [19:0] amp;
        logic [24:0]        phase;
        logic               active;
    } voice_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_op = OP_SAMPLE;
    logic [23:0]        i_phase_step = '0;
    logic [23:0]        i_pulse_width = '0;
    logic [18:0]        i_left_gain = '0;
    logic [18:0]        i_right_gain = '0;
    logic               i_sync_enable = 1'b0;
    logic [16:0]        i_ring_mix = '0;
    logic [24:0]        i_mod_phase = '0;
    logic [23:0]        i_mod_step = '0;
    logic signed [19:0] i_mod_amp = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [19:0] o_left_sample;
    logic signed [19:0] o_right_sample;
    logic signed [19:0] o_voice_amp;
    logic [24:0]        o_voice_phase;
    logic               o_voice_active;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = CFG_WAVE_MODE;
    logic [24:0]        i_cfg_wdata = '0;

    synth_voice_sample_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_phase_step   (i_phase_step),
        .i_pulse_width  (i_pulse_width),
        .i_left_gain    (i_left_gain),
        .i_right_gain   (i_right_gain),
        .i_sync_enable  (i_sync_enable),
        .i_ring_mix     (i_ring_mix),
        .i_mod_phase    (i_mod_phase),
        .i_mod_step     (i_mod_step),
        .i_mod_amp      (i_mod_amp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample),
        .o_voice_amp    (o_voice_amp),
        .o_voice_phase  (o_voice_phase),
        .o_voice_active (o_voice_active),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Beats waiting for the driver, and result beats the voice still owes us.
    voice_beat_t   pending_beats[$];
    voice_result_t owed_results[$];

    int  mismatches = 0;
    int  beats_sent = 0;
    int  results_seen = 0;
    bit  no_idle = 1'b0;       // When set, neither side inserts gaps.
    int  hold_request = 0;     // Long receiver stall asked for by the sequencer.

    // Shadow copy of the configuration registers.
    longint cfg_wave, cfg_attack, cfg_decay, cfg_sustain;
    longint cfg_release, cfg_filter, cfg_cutoff, cfg_damp;

    // Shadow copy of the voice state.
    t_env        env_st;
    longint      env_lvl, osc_ph, flt_low, flt_band, flt_high;
    longint      gain_l, gain_r, held_amp;
    logic [22:0] lfsr;

    function automatic longint clamp20(input longint v);
        if (v > 524287) begin
            return 524287;
        end
        if (v < -524288) begin
            return -524288;
        end
        return v;
    endfunction

    // Quarter-wave sine value by a short Taylor-like series in Q30.
    function automatic longint sine_quarter(input longint unsigned j);
        longint unsigned dv[5];
        longint unsigned x, x2, t;
        dv = '{110, 72, 42, 20, 6};
        x  = (j * TWO_PI_Q30) >> SINE_TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int k = 0; k < 5; k++) begin
            t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[k];
        end
        return longint'((((x * t) >> 30) + 64'd8192) >> 14);
    endfunction

    function automatic longint sine_lookup(input longint idx);
        longint q, quad, j, v;
        q    = 1 << (SINE_TABLE_BITS - 2);
        quad = (idx >> (SINE_TABLE_BITS - 2)) & 3;
        j    = idx & (q - 1);
        v    = (quad & 1) ? sine_quarter(q - j) : sine_quarter(j);
        return (quad & 2) ? -v : v;
    endfunction

    task automatic env_advance();
        longint sus;
        sus = (cfg_sustain > 65536) ? 65536 : cfg_sustain;
        case (env_st)
            ENV_ATTACK: begin
                env_lvl += (cfg_attack + 128) >> 8;
                if (env_lvl > 65536) begin
                    env_lvl = 65536;
                    env_st  = ENV_HOLD;
                end
            end
            ENV_HOLD: begin
                env_lvl = sus + (((env_lvl - sus) * cfg_decay) >>> 24);
            end
            default: begin
                env_lvl = (env_lvl * cfg_release) >> 24;
                if (env_lvl < 7) begin
                    env_st = ENV_OFF;
                end
            end
        endcase
    endtask

    task automatic osc_wave(input longint pw, output longint amp);
        logic [7:0] taps;
        if (cfg_wave == WAVE_PULSE) begin
            amp = (osc_ph < pw) ? -65536 : 65536;
        end else if (cfg_wave == WAVE_TRI) begin
            if (osc_ph < pw) begin
                amp = (osc_ph * 131072) / pw - 65536;
            end else begin
                amp = 65536 - ((osc_ph - pw) * 131072) / ((1 << 24) - pw);
            end
        end else if (cfg_wave == WAVE_SINE) begin
            amp = sine_lookup((osc_ph >> (24 - SINE_TABLE_BITS)) & ((1 << SINE_TABLE_BITS) - 1));
        end else begin
            // Each tick of 0.1 in phase clocks the shift register once.
            while (osc_ph > 1677722) begin
                osc_ph -= 1677722;
                lfsr = {lfsr[21:0], lfsr[22] ^ lfsr[17]};
            end
            taps = {lfsr[22], lfsr[20], lfsr[16], lfsr[13], lfsr[11], lfsr[7], lfsr[4], lfsr[2]};
            amp  = longint'(taps) * 16 * 32 - 65536;
        end
    endtask

    function automatic longint gain_smooth(input longint s, input longint gain);
        longint v, r;
        v = (env_lvl * gain) >> 16;
        r = (s * 63570 + v * 1966 + 32768) >> 16;
        return (r > 524287) ? 524287 : r;
    endfunction

    // Applies one accepted beat to the shadow voice; a sample beat owes a result.
    task automatic voice_predict(input voice_beat_t b);
        voice_result_t res;
        longint amp, ring, cut, mix, left, right;
        left  = 0;
        right = 0;
        ring  = (b.ring > 65536) ? 65536 : b.ring;
        if (b.op == OP_NOTE_ON) begin
            env_st  = ENV_ATTACK;
            env_lvl = 0;
            osc_ph  = 0;
            return;
        end
        if (b.op == OP_NOTE_OFF) begin
            if (env_st != ENV_OFF) begin
                env_st = ENV_RELEASE;
            end
            return;
        end
        if (b.op != OP_SAMPLE) begin
            return;
        end
        if (env_st != ENV_OFF) begin
            env_advance();
            osc_ph = (osc_ph + b.step) & 64'h1ffffff;
            if (cfg_wave != WAVE_NOISE) begin
                osc_ph &= 64'hffffff;
            end
            // Hard sync: the modulator wrapped during this sample.
            if (b.sync && b.mph < b.mst) begin
                osc_ph = (longint'(b.mph) * b.step) / b.mst;
            end
            osc_wave(b.pw, amp);
            if (cfg_filter != 0) begin
                cut      = (cfg_cutoff > 65536) ? 65536 : cfg_cutoff;
                flt_high = clamp20(amp - ((flt_band * cfg_damp) >>> 16) - flt_low);
                flt_band = clamp20(flt_band + ((cut * flt_high) >>> 16));
                flt_low  = clamp20(flt_low + ((cut * flt_band) >>> 16));
                mix = 0;
                if (cfg_filter[FLT_LOW_BIT]) begin
                    mix += flt_low;
                end
                if (cfg_filter[FLT_BAND_BIT]) begin
                    mix += flt_band;
                end
                if (cfg_filter[FLT_HIGH_BIT]) begin
                    mix += flt_high;
                end
                amp = clamp20(mix);
            end
            held_amp = amp;
            amp = clamp20((amp * ((65536 - ring) * 65536 + longint'(b.mamp) * ring)) >>> 32);
            gain_l = gain_smooth(gain_l, b.lg);
            gain_r = gain_smooth(gain_r, b.rg);
            left   = clamp20((amp * gain_l) >>> 16);
            right  = clamp20((amp * gain_r) >>> 16);
        end
        res.left   = left[19:0];
        res.right  = right[19:0];
        res.amp    = held_amp[19:0];
        res.phase  = osc_ph[24:0];
        res.active = (env_st != ENV_OFF);
        owed_results.push_back(res);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // Driver: takes the next beat from the pending queue once the current one is
    // accepted, after a random gap. The shadow voice advances at acceptance.
    int send_gap = 0;
    always @(posedge i_clk) begin
        voice_beat_t b;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                b.op = i_op;             b.step = i_phase_step;
                b.pw = i_pulse_width;    b.lg = i_left_gain;
                b.rg = i_right_gain;     b.sync = i_sync_enable;
                b.ring = i_ring_mix;     b.mph = i_mod_phase;
                b.mst = i_mod_step;      b.mamp = i_mod_amp;
                voice_predict(b);
                beats_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    b = pending_beats.pop_front();
                    i_op          <= b.op;
                    i_phase_step  <= b.step;
                    i_pulse_width <= b.pw;
                    i_left_gain   <= b.lg;
                    i_right_gain  <= b.rg;
                    i_sync_enable <= b.sync;
                    i_ring_mix    <= b.ring;
                    i_mod_phase   <= b.mph;
                    i_mod_step    <= b.mst;
                    i_mod_amp     <= b.mamp;
                    i_in_valid    <= 1'b1;
                    send_gap = draw_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result beat against the oldest owed one and
    // stalls the result channel at random, or for a long stretch on request.
    int recv_stall = 0;
    int recv_hold = 0;
    always @(posedge i_clk) begin
        voice_result_t w;
        logic rdy;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            rdy = 1'b1;
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    report("unexpected result beat", 1, 0);
                end else begin
                    w = owed_results.pop_front();
                    if (o_left_sample !== w.left) report("left_sample", o_left_sample, w.left);
                    if (o_right_sample !== w.right) begin
                        report("right_sample", o_right_sample, w.right);
                    end
                    if (o_voice_amp !== w.amp) report("voice_amp", o_voice_amp, w.amp);
                    if (o_voice_phase !== w.phase) begin
                        report("voice_phase", o_voice_phase, w.phase);
                    end
                    if (o_voice_active !== w.active) begin
                        report("voice_active", o_voice_active, w.active);
                    end
                end
                recv_stall = draw_gap();
            end
            if (hold_request > 0) begin
                recv_hold = hold_request;
                hold_request = 0;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                rdy = 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                rdy = 1'b0;
            end
            i_out_ready <= rdy;
        end
    end

    function automatic voice_beat_t mk_beat(input logic [1:0] op, input longint step,
                                            input longint pw, input longint lg,
                                            input longint rg, input logic sync,
                                            input longint ring, input longint mph,
                                            input longint mst, input longint mamp);
        voice_beat_t b;
        b.op = op;           b.step = step[23:0];  b.pw = pw[23:0];
        b.lg = lg[18:0];     b.rg = rg[18:0];      b.sync = sync;
        b.ring = ring[16:0]; b.mph = mph[24:0];    b.mst = mst[23:0];
        b.mamp = mamp[19:0];
        return b;
    endfunction

    // Random beat: mostly samples with random content, some note events.
    function automatic voice_beat_t random_beat();
        voice_beat_t b;
        int r;
        r = $urandom_range(0, 99);
        b.op   = (r < 4) ? OP_NOTE_ON : (r < 8) ? OP_NOTE_OFF : OP_SAMPLE;
        b.step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hffffff)
                                             : $urandom_range(0, 24'h7ffff);
        b.pw   = $urandom_range(0, 24'hffffff);
        b.lg   = $urandom_range(0, 327680);
        b.rg   = $urandom_range(0, 327680);
        b.sync = $urandom_range(0, 1);
        b.ring = ($urandom_range(0, 2) == 0) ? 17'd0 : 17'($urandom_range(0, 65536));
        b.mst  = $urandom_range(0, 24'hffffff);
        b.mph  = ($urandom_range(0, 1) == 0) ? 25'($urandom_range(0, b.mst))
                                             : 25'($urandom_range(0, 25'h1ffffff));
        b.mamp = 20'($urandom_range(0, 20'hfffff));
        return b;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input longint value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value[24:0];
        case (idx)
            CFG_WAVE_MODE:      cfg_wave    = value & 3;
            CFG_ATTACK_STEP:    cfg_attack  = value & 25'h1ffffff;
            CFG_DECAY_FACTOR:   cfg_decay   = value & 24'hffffff;
            CFG_SUSTAIN_LEVEL:  cfg_sustain = value & 17'h1ffff;
            CFG_RELEASE_FACTOR: cfg_release = value & 24'hffffff;
            CFG_FILTER_MODE:    cfg_filter  = value & 7;
            CFG_CUTOFF:         cfg_cutoff  = value & 17'h1ffff;
            default:            cfg_damp    = value & 17'h1ffff;
        endcase
    endtask

    task automatic cfg_all(input longint wm, input longint att, input longint dec,
                           input longint sus, input longint rel, input longint flt,
                           input longint cut, input longint damp);
        cfg_write(CFG_WAVE_MODE, wm);
        cfg_write(CFG_ATTACK_STEP, att);
        cfg_write(CFG_DECAY_FACTOR, dec);
        cfg_write(CFG_SUSTAIN_LEVEL, sus);
        cfg_write(CFG_RELEASE_FACTOR, rel);
        cfg_write(CFG_FILTER_MODE, flt);
        cfg_write(CFG_CUTOFF, cut);
        cfg_write(CFG_RESONANCE_DAMP, damp);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until the voice owes nothing, then lets any note beat settle.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_beats.size() != 0 || i_in_valid || owed_results.size() != 0);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        cfg_wave = WAVE_PULSE;  cfg_attack = 380;          cfg_decay = 16762939;
        cfg_sustain = 32768;    cfg_release = 16768457;    cfg_filter = 0;
        cfg_cutoff = 13107;     cfg_damp = 32768;
        env_st = ENV_OFF;       env_lvl = 0;   osc_ph = 0;  lfsr = NOISE_SEED;
        flt_low = 0;  flt_band = 0;  flt_high = 0;
        gain_l = 0;   gain_r = 0;    held_amp = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part on reset settings: a sample while off, a release on an
        // idle voice, then field extremes, sync and full ring modulation.
        @(negedge i_clk);
        pending_beats.push_back(mk_beat(OP_SAMPLE, 1000, 0, 65536, 65536, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_NOTE_OFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_NOTE_ON, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_SAMPLE, 24'hffffff, 24'hffffff, 327680, 327680,
                                        0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_SAMPLE, 24'hffffff, 0, 327680, 0, 1, 65536,
                                        25'h1ffffff, 24'hffffff, 524287));
        pending_beats.push_back(mk_beat(OP_SAMPLE, 5000000, 8000000, 0, 327680, 1, 65536,
                                        100, 24'hffffff, -524288));
        pending_beats.push_back(mk_beat(OP_SAMPLE, 24'hffffff, 123, 200000, 300000, 1,
                                        32768, 0, 1, 12345));
        pending_beats.push_back(mk_beat(OP_NOTE_OFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_SAMPLE, 700000, 24'h800000, 327680, 327680, 0,
                                        0, 0, 0, 0));
        drain();
        // Triangle, sine and noise with the filter fully mixed and fast stages.
        for (int m = 1; m <= 3; m++) begin
            cfg_all(m, 16777216, 8000000, 65536, 0, 7, 65536, 131071);
            @(negedge i_clk);
            pending_beats.push_back(mk_beat(OP_NOTE_ON, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            pending_beats.push_back(mk_beat(OP_SAMPLE, 24'hffffff, 0, 327680, 327680, 0, 0,
                                            0, 0, 0));
            pending_beats.push_back(mk_beat(OP_SAMPLE, 24'hffffff, 24'hffffff, 327680,
                                            327680, 0, 0, 0, 0, 0));
            pending_beats.push_back(mk_beat(OP_SAMPLE, 3000000, 24'h400000, 100000, 200000,
                                            0, 65536, 0, 0, -524288));
            pending_beats.push_back(mk_beat(OP_NOTE_OFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            pending_beats.push_back(mk_beat(OP_SAMPLE, 3000000, 24'h400000, 100000, 200000,
                                            0, 0, 0, 0, 0));
            drain();
        end

        // Random phases, each with fresh settings; the first two take the extremes.
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                cfg_all(3, 16777216, 16777215, 65536, 16777215, 7, 65536, 131071);
            end else if (ph == 1) begin
                cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
            end else begin
                cfg_all($urandom_range(0, 3),
                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(128, 16777216),
                        $urandom_range(0, 16777215), $urandom_range(0, 65536),
                        $urandom_range(12000000, 16777215), $urandom_range(0, 7),
                        $urandom_range(0, 65536),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                    : $urandom_range(32768, 72090));
            end
            no_idle = (ph == 4);
            @(negedge i_clk);
            pending_beats.push_back(mk_beat(OP_NOTE_ON, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            for (int n = 0; n < 93; n++) begin
                pending_beats.push_back(random_beat());
            end
            // Hold the result channel off while the sender keeps offering beats.
            if (ph == 6) begin
                hold_request = 400;
            end
            drain();
        end
        no_idle = 1'b0;

        $display("Covered %0d input beats and %0d result beats over all four waves,", beats_sent,
                 results_seen);
        $display("every filter mix, sync, ring modulation and all envelope stages.");
        if (mismatches == 0) begin
            $display("PASS synth_voice_sample_top");
        end else begin
            $display("FAIL synth_voice_sample_top");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL synth_voice_sample_top");
        $finish;
    end

endmodule
